>>> design/uvst_pkg.sv
// Package for the unique value set table: action, status and command codes,
// field widths and the command record that the front passes to the back.
// No dependencies.
package uvst_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_CLEAR   = 3'd2,
    ACT_REPLACE = 3'd3,
    ACT_FIND    = 3'd4
  } uvst_action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_MISSING = 3'd3,
    ST_BADSUB  = 3'd4,
    ST_BADPOS  = 3'd5
  } uvst_status_e;

  typedef enum logic [2:0] {
    K_INSERT,
    K_REMOVE,
    K_CLEAR,
    K_REPLACE,
    K_FIND,
    K_REPORT
  } uvst_kind_e;

  typedef struct packed {
    uvst_kind_e                kind;
    uvst_status_e              status;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  substitute;
    logic [POS_W-1:0]          pos_m1;
    logic                      val_zero;
  } uvst_cmd_t;

endpackage

>>> design/unique_value_set_table_unit.sv
// Top level of the unique value set table: a command front end, a two-entry
// queue and a scanning back end. Depends on uvst_pkg, uvst_front, uvst_queue
// and uvst_back.
//
// Commands enter on the s_axis channel: the action code on tuser, the value,
// position and substitute on tdata. Each command gives exactly one result on
// the m_axis channel: the status on tuser, the zero-based slot on tdata.
// A command that needs the table is resolved by scanning every slot of the
// table memory in order, one slot per cycle through its single read port; the
// back end takes no new command until that result has entered the output
// register. Commands that are decided from their fields alone (unused codes,
// zero insert, remove or find values, a bad position or a zero substitute)
// skip the scan and go straight to the output register. The queue accepts
// up to two commands while the back end is busy. When the receiver stalls,
// the result stays in the output register and the back end waits with its
// next result, while the queue keeps accepting until full. Reset empties
// every slot at once and clears the queue and the output valid flag.
module unique_value_set_table_unit import uvst_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // value [31:0], position [36:32], substitute [68:37]
  input  logic [2:0]  s_axis_tuser,  // action [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // slot_index [3:0]
  output logic [2:0]  m_axis_tuser   // status [2:0]
);

  uvst_cmd_t        push_cmd, pop_cmd;
  logic             push_valid, push_ready, pop_valid, pop_ready;
  uvst_status_e     out_status;
  logic [IDX_W-1:0] out_slot;

  uvst_front #(.TABLE_SLOTS(TABLE_SLOTS)) u_front (
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .action_i     (s_axis_tuser),
    .value_i      (s_axis_tdata[31:0]),
    .position_i   (s_axis_tdata[36:32]),
    .substitute_i (s_axis_tdata[68:37]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .cmd_o        (push_cmd)
  );

  uvst_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  uvst_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (pop_valid),
    .cmd_ready_o  (pop_ready),
    .cmd_i        (pop_cmd),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_slot_o   (out_slot)
  );

  assign m_axis_tdata = {4'b0, out_slot};
  assign m_axis_tuser = out_status;

endmodule

>>> design/uvst_front.sv
// Front end of the unique value set table: accepts commands and classifies
// them, resolving the cases that need no table scan. Depends on uvst_pkg.
module uvst_front import uvst_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [ACT_W-1:0]         action_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] substitute_i,
  output logic                     push_valid_o,
  input  logic                     push_ready_i,
  output uvst_cmd_t                cmd_o
);

  logic pos_bad;

  assign pos_bad = (position_i == '0) || (32'(position_i) > 32'(TABLE_SLOTS));

  always_comb begin
    cmd_o.kind       = K_REPORT;
    cmd_o.status     = ST_MISSING;
    cmd_o.value      = value_i;
    cmd_o.substitute = substitute_i;
    cmd_o.pos_m1     = POS_W'(position_i - 5'd1);
    cmd_o.val_zero   = (value_i == '0);
    unique case (action_i)
      ACT_INSERT: begin
        if (value_i != '0) cmd_o.kind = K_INSERT;
      end
      ACT_REMOVE: begin
        if (value_i != '0) cmd_o.kind = K_REMOVE;
      end
      ACT_FIND: begin
        if (value_i != '0) cmd_o.kind = K_FIND;
      end
      ACT_CLEAR: begin
        if (pos_bad) begin
          cmd_o.status = ST_BADPOS;
        end else begin
          cmd_o.kind = K_CLEAR;
        end
      end
      ACT_REPLACE: begin
        if (substitute_i == '0) begin
          cmd_o.status = ST_BADSUB;
        end else begin
          cmd_o.kind = K_REPLACE;
        end
      end
      default: ;
    endcase
  end

  assign push_valid_o = valid_i;
  assign ready_o      = push_ready_i;

endmodule

>>> design/uvst_queue.sv
// Two-entry command queue between the front and the back of the unique value
// set table. Depends on uvst_pkg.
module uvst_queue import uvst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  uvst_cmd_t push_cmd_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output uvst_cmd_t pop_cmd_o
);

  uvst_cmd_t  entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

>>> design/uvst_back.sv
// Back end of the unique value set table: holds the table memory, scans it
// one slot per cycle, applies the command and registers the result.
// Depends on uvst_pkg.
module uvst_back import uvst_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  uvst_cmd_t         cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output uvst_status_e      out_status_o,
  output logic [IDX_W-1:0]  out_slot_o
);

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam logic [CNT_W-1:0]  SlotsCnt = CNT_W'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] LastIdx  = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {B_IDLE, B_SCAN, B_DONE} back_state_e;

  back_state_e              state_q;
  uvst_cmd_t                cmd_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     rd_vld_q;
  logic [SLOT_W-1:0]        rd_idx_q;
  logic                     vfound_q, sfound_q, efound_q, posfull_q;
  logic [SLOT_W-1:0]        vidx_q, eidx_q;
  logic                     out_vld_q;
  uvst_status_e             out_status_q;
  logic [IDX_W-1:0]         out_slot_q;

  logic signed [DATA_W-1:0] mem_q [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0]   valid_q;
  logic signed [DATA_W-1:0] rd_data_q;
  logic                     rd_ok_q;
  logic [SLOT_W-1:0]        rd_addr;

  logic signed [DATA_W-1:0] rd_word;
  logic                     hit_val, hit_sub, hit_empty, at_pos;
  logic [SLOT_W-1:0]        pos_addr;
  uvst_status_e             res_status;
  logic [SLOT_W-1:0]        res_slot;
  logic [SLOT_W+3:0]        slot_ext;
  logic                     wr_need, wr_en, done_fire, pop;
  logic signed [DATA_W-1:0] wr_data;

  assign cmd_ready_o = (state_q == B_IDLE);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign rd_addr     = cnt_q[SLOT_W-1:0];
  assign pos_addr    = SLOT_W'(cmd_q.pos_m1);

  assign rd_word   = rd_ok_q ? rd_data_q : '0;
  assign hit_val   = !cmd_q.val_zero && (rd_word == cmd_q.value);
  assign hit_sub   = (rd_word == cmd_q.substitute);
  assign hit_empty = (rd_word == '0);
  assign at_pos    = (rd_idx_q == pos_addr);

  always_comb begin
    res_status = ST_MISSING;
    res_slot   = '0;
    wr_need    = 1'b0;
    wr_data    = '0;
    case (cmd_q.kind)
      K_INSERT: begin
        if (vfound_q) begin
          res_status = ST_PRESENT;
        end else if (efound_q) begin
          res_status = ST_OK;
          res_slot   = eidx_q;
          wr_need    = 1'b1;
          wr_data    = cmd_q.value;
        end else begin
          res_status = ST_FULL;
        end
      end
      K_REMOVE: begin
        if (vfound_q) begin
          res_status = ST_OK;
          res_slot   = vidx_q;
          wr_need    = 1'b1;
        end
      end
      K_CLEAR: begin
        if (posfull_q) begin
          res_status = ST_OK;
          res_slot   = pos_addr;
          wr_need    = 1'b1;
        end
      end
      K_REPLACE: begin
        if (sfound_q) begin
          res_status = ST_BADSUB;
        end else if (vfound_q) begin
          res_status = ST_OK;
          res_slot   = vidx_q;
          wr_need    = 1'b1;
          wr_data    = cmd_q.substitute;
        end
      end
      K_FIND: begin
        if (vfound_q) begin
          res_status = ST_OK;
          res_slot   = vidx_q;
        end
      end
      K_REPORT: res_status = cmd_q.status;
      default: ;
    endcase
  end

  assign done_fire = (state_q == B_DONE) && (!out_vld_q || out_ready_i);
  assign wr_en     = done_fire && wr_need;
  assign slot_ext  = {4'b0, res_slot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
      vfound_q  <= 1'b0;
      sfound_q  <= 1'b0;
      efound_q  <= 1'b0;
      posfull_q <= 1'b0;
      vidx_q    <= '0;
      eidx_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          rd_vld_q <= 1'b0;
          if (cmd_valid_i) begin
            cnt_q     <= '0;
            vfound_q  <= 1'b0;
            sfound_q  <= 1'b0;
            efound_q  <= 1'b0;
            posfull_q <= 1'b0;
            state_q   <= (cmd_i.kind == K_REPORT) ? B_DONE : B_SCAN;
          end
        end
        B_SCAN: begin
          if (cnt_q != SlotsCnt) begin
            rd_vld_q <= 1'b1;
            rd_idx_q <= cnt_q[SLOT_W-1:0];
            cnt_q    <= cnt_q + 1'b1;
          end else begin
            rd_vld_q <= 1'b0;
          end
          if (rd_vld_q) begin
            if (hit_val && !vfound_q) begin
              vfound_q <= 1'b1;
              vidx_q   <= rd_idx_q;
            end
            if (hit_sub) sfound_q <= 1'b1;
            if (hit_empty && !efound_q) begin
              efound_q <= 1'b1;
              eidx_q   <= rd_idx_q;
            end
            if (at_pos && !hit_empty) posfull_q <= 1'b1;
            if (rd_idx_q == LastIdx) state_q <= B_DONE;
          end
        end
        B_DONE: begin
          if (done_fire) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
      if (done_fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) cmd_q <= cmd_i;
    if (done_fire) begin
      out_status_q <= res_status;
      out_slot_q   <= slot_ext[3:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[res_slot] <= wr_data;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (wr_en) valid_q[res_slot] <= 1'b1;
      rd_ok_q <= valid_q[rd_addr];
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;

  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == B_SCAN)
    else $error("table read returned outside a scan");

  a_write_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> state_q == B_IDLE && out_vld_q)
    else $error("table write not followed by a result");

  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> state_q == B_SCAN || state_q == B_DONE)
    else $error("accepted command did not start");

  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_status_q != ST_OK |-> out_slot_q == '0)
    else $error("nonzero slot on a failed command");

endmodule

>>> test/unique_value_set_table_unit_test.sv
// Self-checking testbench for unique_value_set_table_unit: directed and random table
// commands with random stalls on both streams, checked against an internal table model.
// Depends on uvst_pkg and the unique_value_set_table_unit RTL.
`timescale 1ns / 1ps

module unique_value_set_table_unit_test;
  import uvst_pkg::*;

  localparam int TABLE_SLOTS = 16;
  localparam int POOL_SIZE = 20;
  localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [POS_W-1:0] POS_NONE = 5'd0;

  typedef struct {
    uvst_status_e status;
    logic [IDX_W-1:0] slot;
  } table_result_t;

  class table_scoreboard;
    logic [DATA_W-1:0] slots[TABLE_SLOTS];
    table_result_t expected_q[$];
    int errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      errors = 0;
    endfunction

    function int first_slot(logic [DATA_W-1:0] key);
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (slots[i] == key) return i;
      end
      return TABLE_SLOTS;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_command(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val,
                               logic [POS_W-1:0] pos, logic [DATA_W-1:0] sub);
      table_result_t res;
      int hit;
      res.status = ST_MISSING;
      hit = 0;
      case (act)
        ACT_INSERT: begin
          if (val != 0) begin
            if (first_slot(val) < TABLE_SLOTS) begin
              res.status = ST_PRESENT;
            end else begin
              hit = first_slot('0);
              if (hit < TABLE_SLOTS) begin
                slots[hit] = val;
                res.status = ST_OK;
              end else begin
                res.status = ST_FULL;
              end
            end
          end
        end
        ACT_REMOVE: begin
          if (val != 0) begin
            hit = first_slot(val);
            if (hit < TABLE_SLOTS) begin
              slots[hit] = '0;
              res.status = ST_OK;
            end
          end
        end
        ACT_CLEAR: begin
          if (pos == 0 || pos > TABLE_SLOTS) begin
            res.status = ST_BADPOS;
          end else begin
            hit = pos - 1;
            if (slots[hit] != 0) begin
              slots[hit] = '0;
              res.status = ST_OK;
            end
          end
        end
        ACT_REPLACE: begin
          if (sub == 0 || first_slot(sub) < TABLE_SLOTS) begin
            res.status = ST_BADSUB;
          end else if (val != 0) begin
            hit = first_slot(val);
            if (hit < TABLE_SLOTS) begin
              slots[hit] = sub;
              res.status = ST_OK;
            end
          end
        end
        ACT_FIND: begin
          if (val != 0) begin
            hit = first_slot(val);
            if (hit < TABLE_SLOTS) res.status = ST_OK;
          end
        end
        default: begin
        end
      endcase
      res.slot = (res.status == ST_OK) ? hit[IDX_W-1:0] : '0;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic [STAT_W-1:0] status, logic [IDX_W-1:0] slot);
      table_result_t res;
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d slot_index %0d", status, slot);
        errors++;
        return;
      end
      res = expected_q.pop_front();
      if (status !== res.status) begin
        $error("status: expected %0d, actual %0d", res.status, status);
        errors++;
      end
      if (slot !== res.slot) begin
        $error("slot_index: expected %0d, actual %0d", res.slot, slot);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // value [31:0], position [36:32], substitute [68:37]
  logic [2:0] s_axis_tuser = '0;   // action [2:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // slot_index [3:0]
  logic [2:0] m_axis_tuser;        // status [2:0]

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic [DATA_W-1:0] value_pool[POOL_SIZE];
  table_scoreboard sb = new();

  unique_value_set_table_unit #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata[IDX_W-1:0]);
    end
    if (s_axis_tvalid && s_axis_tready) begin
      sb.note_command(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[36:32],
                      s_axis_tdata[68:37]);
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
                          input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] sub);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, sub, pos, val};
    s_axis_tuser <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 16) return $urandom;
    return value_pool[$urandom_range(POOL_SIZE - 1)];
  endfunction

  task automatic run_random(input int count);
    int ins_pct;
    int s;
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    for (int i = 0; i < count; i++) begin
      ins_pct = ((i / 40) % 2) ? 25 : 60;
      if ($urandom_range(99) < ins_pct) begin
        act = ACT_INSERT;
      end else begin
        s = $urandom_range(19);
        if (s < 5) act = ACT_REMOVE;
        else if (s < 9) act = ACT_CLEAR;
        else if (s < 14) act = ACT_REPLACE;
        else if (s < 19) act = ACT_FIND;
        else act = ACT_W'(ACT_SPARE_FIRST + $urandom_range(2));
      end
      if ($urandom_range(99) < 85) pos = POS_W'($urandom_range(TABLE_SLOTS, 1));
      else pos = POS_W'($urandom_range(31));
      send_cmd(act, pick_value(), pos, pick_value());
    end
  endtask

  initial begin
    value_pool[0] = MOST_NEG;
    value_pool[1] = MOST_POS;
    value_pool[2] = ALL_ONES;
    value_pool[3] = 32'd1;
    for (int i = 4; i < POOL_SIZE; i++) begin
      value_pool[i] = $urandom;
      if (value_pool[i] == 0) value_pool[i] = 32'd2;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(ACT_INSERT, '0, POS_NONE, '0);
    send_cmd(ACT_INSERT, MOST_NEG, POS_NONE, '0);
    send_cmd(ACT_INSERT, MOST_POS, POS_NONE, '0);
    send_cmd(ACT_INSERT, ALL_ONES, POS_NONE, '0);
    send_cmd(ACT_INSERT, MOST_POS, POS_NONE, '0);
    send_cmd(ACT_FIND, MOST_NEG, POS_NONE, '0);
    send_cmd(ACT_FIND, '0, POS_NONE, '0);
    send_cmd(ACT_FIND, 32'd5, POS_NONE, '0);
    send_cmd(ACT_REMOVE, MOST_POS, POS_NONE, '0);
    send_cmd(ACT_REMOVE, '0, POS_NONE, '0);
    send_cmd(ACT_REMOVE, 32'd5, POS_NONE, '0);
    send_cmd(ACT_CLEAR, '0, 5'd0, '0);
    send_cmd(ACT_CLEAR, '0, 5'd17, '0);
    send_cmd(ACT_CLEAR, ALL_ONES, 5'd31, ALL_ONES);
    send_cmd(ACT_CLEAR, '0, 5'd2, '0);
    send_cmd(ACT_REPLACE, ALL_ONES, POS_NONE, '0);
    send_cmd(ACT_REPLACE, ALL_ONES, POS_NONE, MOST_NEG);
    send_cmd(ACT_REPLACE, '0, POS_NONE, 32'd9);
    send_cmd(ACT_REPLACE, 32'd5, POS_NONE, 32'd9);
    send_cmd(ACT_REPLACE, ALL_ONES, POS_NONE, 32'd9);
    send_cmd(ACT_CLEAR, '0, 5'd3, '0);
    send_cmd(ACT_CLEAR, '0, 5'd16, '0);
    for (int k = 0; k < 3; k++) begin
      send_cmd(ACT_W'(ACT_SPARE_FIRST + k), MOST_NEG, 5'd1, MOST_POS);
    end
    drain();

    send_idle_pct = 8;
    recv_idle_pct = 77;
    run_random(230);
    drain();
    send_idle_pct = 77;
    recv_idle_pct = 8;
    run_random(230);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(230);
    drain();

    repeat (TABLE_SLOTS + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("unique_value_set_table_unit verification clean");
    end else begin
      $display("unique_value_set_table_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("unique_value_set_table_unit verification failed");
    $finish;
  end

endmodule

>>> sim.f
design/uvst_pkg.sv
design/uvst_front.sv
design/uvst_queue.sv
design/uvst_back.sv
design/unique_value_set_table_unit.sv
test/unique_value_set_table_unit_test.sv
